// ----- rtl/core/art_pkg.sv -----
package art_pkg;

	localparam int ADDR_W      = 64;
	localparam int LEN_W       = 32;
	localparam int SLOT_W      = 4;
	localparam int STAT_W      = 2;
	localparam int REGIONS_DEF = 16;

	// command codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	// status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_e;

	// one command beat
	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  length;
	} art_req_t;

	// one result beat
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] found_start;
		logic [ADDR_W-1:0] found_end;
	} art_rsp_t;

	// one stored region, both bounds inclusive
	typedef struct packed {
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
	} region_t;

endpackage

// ----- rtl/core/art_mem.sv -----
module art_mem #(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IW-1:0]    wr_idx,
	input  art_pkg::region_t wr_data,
	input  logic             rd_en,
	input  logic [IW-1:0]    rd_idx,
	output art_pkg::region_t rd_data
);
	import art_pkg::*;

	region_t mem [DEPTH];
	region_t rd_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/core/art_match.sv -----
module art_match (
	input  logic                      mode,
	input  logic [art_pkg::ADDR_W-1:0] key,
	input  logic [art_pkg::ADDR_W-1:0] new_hi,
	input  art_pkg::region_t          ent,
	output logic                      hit
);
	import art_pkg::*;

	logic conflict;
	logic holds;

	// add: conflict rule between stored (lo, hi) and new (key, new_hi)
	always_comb begin
		conflict = (ent.lo == key) || (ent.hi == new_hi)
			|| ((ent.lo > key) && (ent.lo < new_hi))
			|| ((ent.hi > key) && (ent.hi < new_hi))
			|| ((ent.lo < key) && (ent.hi > new_hi))
			|| ((ent.lo > key) && (ent.hi < new_hi));
	end

	// find: inclusive containment
	assign holds = (key >= ent.lo) && (key <= ent.hi);

	assign hit = (mode == CMD_FIND) ? holds : conflict;

endmodule

// ----- rtl/core/address_region_table.sv -----
// Address region table. A command beat (start high while busy is low) either
// adds a region [addr, addr+length] (end wraps modulo 2^64) unless it conflicts
// with a stored one, or finds the first region, in insertion order, that holds
// addr. Exactly one result beat follows each command, shown for one cycle with
// done high; the receiver cannot stall it, so it must take every beat as it
// comes. An add into a full table answers in the cycle after it is accepted.
// Otherwise busy goes high and the stored regions are read from the region
// memory one per cycle, stopping early on a match, with the result shown in the
// first cycle busy is low.
// A new command may be started in the cycle its predecessor's result is shown.
module address_region_table #(
	parameter int REGIONS = art_pkg::REGIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  art_pkg::art_req_t req,
	output logic              done,
	output art_pkg::art_rsp_t rsp
);
	import art_pkg::*;

	localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int CW = $clog2(REGIONS + 1);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t            state_q;
	art_req_t          req_q;
	logic [ADDR_W-1:0] ne_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     rd_idx_q;
	logic              issue_q;
	logic              valid_s1;
	logic              last_s1;
	logic [IW-1:0]     idx_s1;
	logic              done_q;
	art_rsp_t          rsp_q;

	logic              accept;
	logic              last_c;
	logic              ent_hit;
	logic              found;
	logic              miss_end;
	logic              wr_en;
	region_t           rd_data;
	region_t           wr_data;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// last stored entry being issued
	assign last_c = (CW'(rd_idx_q) == (count_q - 1'b1));

	// scan outcome for the entry read back this cycle
	assign found    = (state_q == S_SCAN) && valid_s1 && ent_hit;
	assign miss_end = (state_q == S_SCAN)
		&& ((valid_s1 && last_s1 && !ent_hit) || (count_q == '0));
	assign wr_en    = miss_end && (req_q.cmd == CMD_ADD);

	assign wr_data.lo = req_q.addr;
	assign wr_data.hi = ne_q;

	art_mem #(
		.DEPTH (REGIONS),
		.IW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (count_q[IW-1:0]),
		.wr_data (wr_data),
		.rd_en   (issue_q),
		.rd_idx  (rd_idx_q),
		.rd_data (rd_data)
	);

	art_match u_match (
		.mode   (req_q.cmd),
		.key    (req_q.addr),
		.new_hi (ne_q),
		.ent    (rd_data),
		.hit    (ent_hit)
	);

	// control: accept, scan one entry per cycle, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= '0;
			ne_q     <= '0;
			count_q  <= '0;
			rd_idx_q <= '0;
			issue_q  <= 1'b0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			idx_s1   <= '0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					valid_s1 <= 1'b0;
					if (accept) begin
						req_q <= req;
						ne_q  <= req.addr + ADDR_W'(req.length);
						if ((req.cmd == CMD_ADD) && (count_q == CW'(REGIONS))) begin
							done_q       <= 1'b1;
							rsp_q        <= '0;
							rsp_q.status <= ST_FULL;
						end else begin
							state_q  <= S_SCAN;
							rd_idx_q <= '0;
							issue_q  <= (count_q != '0);
						end
					end
				end
				S_SCAN: begin
					// read issue stage
					if (issue_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						issue_q  <= !last_c;
					end
					valid_s1 <= issue_q;
					last_s1  <= last_c;
					idx_s1   <= rd_idx_q;
					// compare stage
					if (found) begin
						state_q  <= S_IDLE;
						issue_q  <= 1'b0;
						valid_s1 <= 1'b0;
						done_q   <= 1'b1;
						rsp_q    <= '0;
						if (req_q.cmd == CMD_FIND) begin
							rsp_q.status      <= ST_OK;
							rsp_q.hit         <= 1'b1;
							rsp_q.slot        <= SLOT_W'(idx_s1);
							rsp_q.found_start <= rd_data.lo;
							rsp_q.found_end   <= rd_data.hi;
						end else begin
							rsp_q.status <= ST_MISS;
						end
					end else if (miss_end) begin
						state_q  <= S_IDLE;
						issue_q  <= 1'b0;
						valid_s1 <= 1'b0;
						done_q   <= 1'b1;
						rsp_q    <= '0;
						if (req_q.cmd == CMD_ADD) begin
							count_q           <= count_q + 1'b1;
							rsp_q.status      <= ST_OK;
							rsp_q.hit         <= 1'b1;
							rsp_q.slot        <= SLOT_W'(count_q);
							rsp_q.found_start <= req_q.addr;
							rsp_q.found_end   <= ne_q;
						end else begin
							rsp_q.status <= ST_MISS;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result beat only follows a command
	a_done_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("result beat without a command");

	// occupancy never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(REGIONS))
		else $error("region count above table size");

	// a write lands only into a free slot
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q < CW'(REGIONS)))
		else $error("write into a full table");

	// a stored add grows the table by exactly one
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.hit && (req_q.cmd == CMD_ADD))
		|-> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("count not advanced on stored add");

	// read data is only consumed while scanning
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == S_SCAN))
		else $error("compare stage active outside scan");

endmodule
